### rtl/binary_blob_area_centroid_macros.svh
// ----------------------------------------------------------------------------
// Binary blob area and centroid: assertion macros
// Wrappers for concurrent assertions. They are clocked on clk and disabled
// while rst_n is low. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_BLOB_AREA_CENTROID_MACROS_SVH
`define BINARY_BLOB_AREA_CENTROID_MACROS_SVH
`ifndef SYNTHESIS
`define BBAC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbac: same-cycle assertion failed");
`define BBAC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbac: next-cycle assertion failed");
`else
`define BBAC_ASSERT_IMP(label, ante, cons)
`define BBAC_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/bbac_pkg.sv
// ----------------------------------------------------------------------------
// Binary blob area and centroid: package
// Widths, codes, control structs and helper functions shared by the block.
// ----------------------------------------------------------------------------
package bbac_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int DIM_W   = 12;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int PIX_W   = 8;
  localparam int CNT_W   = 23;
  localparam int SUM_W   = 34;
  localparam int DEN_W   = 34;
  localparam int Q_W     = 17;
  localparam int FRAC_W  = 16;
  localparam int STEP_W  = $clog2(Q_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(480);
  localparam logic [Q_W-1:0]   AREA_CAP = Q_W'(65536);
  localparam logic [Q_W-1:0]   CENT_CAP = Q_W'(65535);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_INIT,
    S_DIV,
    S_STORE,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    JOB_AREA,
    JOB_COL,
    JOB_ROW
  } job_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] col_sum;
    logic [SUM_W-1:0] row_sum;
  } totals_t;

  typedef struct packed {
    logic snap;
    logic mul;
    logic init;
    logic step;
    logic store;
    logic out_load;
    job_t job;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0]  set_pixel_count;
    logic [Q_W-1:0]    area_fraction;
    logic [FRAC_W-1:0] centroid_col_fraction;
    logic [FRAC_W-1:0] centroid_row_fraction;
  } result_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/bbac_pix_if.sv
// ----------------------------------------------------------------------------
// Binary blob area and centroid: pixel channel
// Valid/ready channel carrying one 8-bit sample per transfer.
// ----------------------------------------------------------------------------
interface bbac_pix_if;
  logic                       valid;
  logic                       ready;
  logic [bbac_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

### rtl/bbac_res_if.sv
// ----------------------------------------------------------------------------
// Binary blob area and centroid: result channel
// Valid/ready channel carrying one per-frame measurement per transfer.
// ----------------------------------------------------------------------------
interface bbac_res_if;
  logic                        valid;
  logic                        ready;
  logic [bbac_pkg::CNT_W-1:0]  set_pixel_count;
  logic [bbac_pkg::Q_W-1:0]    area_fraction;
  logic [bbac_pkg::FRAC_W-1:0] centroid_col_fraction;
  logic [bbac_pkg::FRAC_W-1:0] centroid_row_fraction;

  modport source (output valid, output set_pixel_count, output area_fraction,
                  output centroid_col_fraction, output centroid_row_fraction,
                  input ready);
  modport sink (input valid, input set_pixel_count, input area_fraction,
                input centroid_col_fraction, input centroid_row_fraction,
                output ready);
endinterface

### rtl/bbac_cfg_if.sv
// ----------------------------------------------------------------------------
// Binary blob area and centroid: configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bbac_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bbac_pkg::CFG_IDX_W-1:0] index;
  logic [bbac_pkg::DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/bbac_accum.sv
// ----------------------------------------------------------------------------
// Binary blob area and centroid: pixel accumulator
// Tracks the raster position and accumulates set-pixel count and position
// sums at one pixel per cycle while accept is high. Flags the transfer that
// ends a frame.
module bbac_accum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [bbac_pkg::PIX_W-1:0] pixel_value,
  input  logic [bbac_pkg::DIM_W-1:0] eff_w,
  input  logic [bbac_pkg::DIM_W-1:0] eff_h,
  output logic                       last_pos,
  output logic                       frame_done,
  output bbac_pkg::totals_t          totals
);
  import bbac_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  totals_t          acc_r, acc_nxt;
  logic             set;
  logic             last_col;
  logic             last_row;

  assign set      = (pixel_value != '0);
  assign last_col = (DIM_W'(col_r) + DIM_W'(1)) >= eff_w;
  assign last_row = (DIM_W'(row_r) + DIM_W'(1)) >= eff_h;
  assign last_pos = last_col && last_row;
  assign frame_done = accept && last_pos;

  always_comb begin
    totals.cnt     = acc_r.cnt + CNT_W'(set);
    totals.col_sum = acc_r.col_sum + (set ? SUM_W'(col_r) : '0);
    totals.row_sum = acc_r.row_sum + (set ? SUM_W'(row_r) : '0);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    acc_nxt = acc_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
      acc_nxt = last_pos ? '0 : totals;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      acc_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      acc_r <= acc_nxt;
    end
  end

endmodule

### rtl/bbac_dp.sv
// ----------------------------------------------------------------------------
// Binary blob area and centroid: frame-end datapath
// Holds the frame totals, forms each divisor with one shared multiplier and
// runs a shared restoring divider one quotient bit per cycle. Drives the
// result output register.
// ----------------------------------------------------------------------------
module bbac_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bbac_pkg::cmd_t             cmd,
  input  bbac_pkg::totals_t          totals,
  input  logic [bbac_pkg::DIM_W-1:0] eff_w,
  input  logic [bbac_pkg::DIM_W-1:0] eff_h,
  input  logic                       out_ready,
  output bbac_pkg::status_t          status,
  output logic                       out_valid,
  output bbac_pkg::result_t          result
);
  import bbac_pkg::*;

  totals_t              tot_r;
  logic [DIM_W-1:0]     w_r;
  logic [DIM_W-1:0]     h_r;
  logic [DEN_W-1:0]     prod_r;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W-1:0]     rem_r;
  logic                 nbit_r;
  logic                 ovf_r;
  logic [Q_W-1:0]       q_r;
  logic [Q_W-1:0]       area_r;
  logic [FRAC_W-1:0]    cx_r;
  logic [FRAC_W-1:0]    cy_r;
  logic                 out_valid_r;
  result_t              res_r;

  logic [CNT_W-1:0]       mul_a;
  logic [DIM_W-1:0]       mul_b;
  logic [CNT_W+DIM_W-1:0] mul_p;
  logic [SUM_W-1:0]       num;
  logic [DEN_W:0]         rem_sh;
  logic [DEN_W+1:0]       diff;
  logic                   ge;
  logic [Q_W-1:0]         cap;
  logic [Q_W-1:0]         qsat;
  logic                   cnt_zero;

  always_comb begin
    unique case (cmd.job)
      JOB_AREA: begin
        mul_a = CNT_W'(h_r);
        mul_b = w_r;
        num   = SUM_W'(tot_r.cnt);
      end
      JOB_COL: begin
        mul_a = tot_r.cnt;
        mul_b = w_r;
        num   = tot_r.col_sum;
      end
      JOB_ROW: begin
        mul_a = tot_r.cnt;
        mul_b = h_r;
        num   = tot_r.row_sum;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        num   = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign rem_sh   = {rem_r, nbit_r};
  assign diff     = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge       = !diff[DEN_W+1];
  assign cnt_zero = (tot_r.cnt == '0);
  assign cap      = (cmd.job == JOB_AREA) ? AREA_CAP : CENT_CAP;
  assign qsat     = (ovf_r || (q_r > cap)) ? cap : q_r;

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      tot_r <= totals;
      w_r   <= eff_w;
      h_r   <= eff_h;
    end
    if (cmd.mul) begin
      prod_r <= mul_p[DEN_W-1:0];
    end
    if (cmd.init) begin
      den_r  <= prod_r;
      ovf_r  <= {2'b00, num} >= {1'b0, prod_r, 1'b0};
      rem_r  <= {1'b0, num[SUM_W-1:1]};
      nbit_r <= num[0];
      q_r    <= '0;
    end else if (cmd.step) begin
      rem_r  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      nbit_r <= 1'b0;
      q_r    <= {q_r[Q_W-2:0], ge};
    end
    if (cmd.store) begin
      unique case (cmd.job)
        JOB_AREA: area_r <= qsat;
        JOB_COL:  cx_r   <= cnt_zero ? '0 : qsat[FRAC_W-1:0];
        JOB_ROW:  cy_r   <= cnt_zero ? '0 : qsat[FRAC_W-1:0];
        default:  area_r <= area_r;
      endcase
    end
    if (cmd.out_load) begin
      res_r.set_pixel_count       <= tot_r.cnt;
      res_r.area_fraction         <= area_r;
      res_r.centroid_col_fraction <= cx_r;
      res_r.centroid_row_fraction <= cy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign result          = res_r;

endmodule

### rtl/bbac_ctrl.sv
// ----------------------------------------------------------------------------
// Binary blob area and centroid: frame-end controller
// Sequences the three divisions (area, column, row) after a frame ends and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module bbac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              frame_done,
  input  bbac_pkg::status_t status,
  output bbac_pkg::cmd_t    cmd,
  output logic              busy
);
  import bbac_pkg::*;

  state_t            state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r   <= JOB_AREA;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.job   = job_r;
    unique case (state_r)
      S_IDLE: begin
        if (frame_done) begin
          cmd.snap  = 1'b1;
          job_nxt   = JOB_AREA;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (step_r == STEP_W'(Q_W - 1)) begin
          state_nxt = S_STORE;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        unique case (job_r)
          JOB_AREA: begin
            job_nxt   = JOB_COL;
            state_nxt = S_MUL;
          end
          JOB_COL: begin
            job_nxt   = JOB_ROW;
            state_nxt = S_MUL;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### rtl/binary_blob_area_centroid.sv
// ----------------------------------------------------------------------------
// Binary blob area and centroid: top level
// Measures the set-pixel count, area fraction and centroid of 8-bit frames.
// ----------------------------------------------------------------------------
// Pixels arrive on in_pix in raster order, one per transfer, and the block
// takes one pixel every cycle except for the frame-end stall below. A pixel
// is set when it is nonzero. Frame width and height come from cfg_wr (index
// 0 width, index 1 height); a value of zero counts as one and a value above
// 2048 counts as 2048. Write them only while the block is idle.
// The transfer that completes the last row ends the frame. One result then
// appears on out_res: the set-pixel count, a Q1.16 area fraction and two
// Q0.16 centroid fractions. The frame-end stage takes a snapshot, then for
// each fraction a multiply, a set-up step, seventeen divider steps and a
// store, and then loads the output register.
// The next frame streams in while that stage works. Only a pixel that would
// end a frame waits while the previous frame's result is still in progress,
// so a short frame waits for the previous frame-end sequence to finish.
// If out_res stalls, the finished result waits in the output register and
// the frame-end stage holds its next result until the register frees.
// Reset sets the width to 640, the height to 480 and clears the position
// and accumulators; no result is pending after reset.
// ----------------------------------------------------------------------------
`include "binary_blob_area_centroid_macros.svh"

module binary_blob_area_centroid (
  input logic      clk,
  input logic      rst_n,
  bbac_pix_if.sink in_pix,
  bbac_res_if.source out_res,
  bbac_cfg_if.sink cfg_wr
);
  import bbac_pkg::*;

  logic [DIM_W-1:0] frame_width_r;
  logic [DIM_W-1:0] frame_height_r;
  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;
  logic             accept;
  logic             last_pos;
  logic             frame_done;
  logic             busy;
  totals_t          totals;
  cmd_t             cmd;
  status_t          status;
  result_t          result;
  logic             out_valid;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      unique case (cfg_idx_t'(cfg_wr.index))
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wr.data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wr.data;
      endcase
    end
  end

  assign eff_w = eff_dim(frame_width_r, DIM_W'(MAX_WIDTH));
  assign eff_h = eff_dim(frame_height_r, DIM_W'(MAX_HEIGHT));

  assign in_pix.ready = !(last_pos && busy);
  assign accept       = in_pix.valid && in_pix.ready;

  bbac_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .pixel_value (in_pix.pixel_value),
    .eff_w       (eff_w),
    .eff_h       (eff_h),
    .last_pos    (last_pos),
    .frame_done  (frame_done),
    .totals      (totals)
  );

  bbac_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_done (frame_done),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  bbac_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .totals    (totals),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .out_ready (out_res.ready),
    .status    (status),
    .out_valid (out_valid),
    .result    (result)
  );

  assign out_res.valid                 = out_valid;
  assign out_res.set_pixel_count       = result.set_pixel_count;
  assign out_res.area_fraction         = result.area_fraction;
  assign out_res.centroid_col_fraction = result.centroid_col_fraction;
  assign out_res.centroid_row_fraction = result.centroid_row_fraction;

  `BBAC_ASSERT_IMP(a_frame_end_when_idle, frame_done, !busy)
  `BBAC_ASSERT_IMP(a_one_command, 1'b1,
                   $onehot0({cmd.snap, cmd.mul, cmd.init, cmd.step, cmd.store, cmd.out_load}))
  `BBAC_ASSERT_NXT(a_load_shows_valid, cmd.out_load, out_res.valid)

endmodule
